// File: hw/rtl/rspe_pkg.sv
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon parity encoder.
// No dependencies; used by rspe_gen and reed_solomon_parity_encoder.
package rspe_pkg;

	// Field polynomial x^8+x^4+x^3+x^2+1 and the top bit of a field element
	localparam logic [8:0] FIELD_POLY = 9'h11D;
	localparam logic [7:0] TOP_BIT    = 8'h80;

	// Register and parameter defaults
	localparam int unsigned ECC_W           = 6;
	localparam int unsigned MAX_ECC_LEN_DEF = 32;
	localparam logic [ECC_W-1:0] ECC_LEN_RESET = 6'd10;

	typedef logic [7:0] gf_elem_t;

	// Multiply by alpha (x) modulo the field polynomial
	function automatic gf_elem_t gf_xtime(input gf_elem_t a);
		gf_elem_t sh;
		sh = {a[6:0], 1'b0};
		if ((a & TOP_BIT) != 8'h00) begin
			sh = sh ^ FIELD_POLY[7:0];
		end
		return sh;
	endfunction

	// General GF(256) multiply, shift-and-add over the eight bits of b
	function automatic gf_elem_t gf_mul(input gf_elem_t a, input gf_elem_t b);
		gf_elem_t acc;
		gf_elem_t x;
		acc = '0;
		x   = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage

// File: hw/rtl/reed_solomon_parity_encoder.sv
// Top level of the systematic Reed-Solomon parity encoder over GF(256).
// Depends on rspe_pkg and rspe_gen.

// Takes one data byte per cycle while data_ready is high. Each accepted byte steps an
// n-stage division LFSR (n = the parity length register, capped at MAX_ECC_LEN) with all
// stages updated in parallel. On the byte marked last, the finished stages drop into an
// output shift register and the LFSR restarts from zero, so the next block can stream in
// while the n parity bytes leave one per cycle as long as parity_ready is high, stage 0 first,
// the final one flagged by last_parity. A last byte is held off (data_ready low) while the
// previous block's parity is still draining, unless its final byte leaves in that same cycle.
// After reset and after every write to the length register the generator polynomial is
// rebuilt, one root per cycle, which keeps data_ready low; a write also clears the LFSR.
// Write the length only when the block is idle.
module reed_solomon_parity_encoder #(
	parameter int unsigned MAX_ECC_LEN = rspe_pkg::MAX_ECC_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [rspe_pkg::ECC_W-1:0] cfg_wdata,
	// data requests
	input  logic                       data_valid,
	output logic                       data_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	// parity requests
	output logic                       parity_valid,
	input  logic                       parity_ready,
	output logic [7:0]                 parity_byte,
	output logic                       last_parity
);
	import rspe_pkg::*;

	localparam int unsigned NW = $clog2(MAX_ECC_LEN + 1);

	logic [ECC_W-1:0]           ecc_q;
	logic [NW-1:0]              len;
	logic                       gen_busy;
	gf_elem_t [MAX_ECC_LEN-1:0] coef;
	gf_elem_t [MAX_ECC_LEN-1:0] stage_q;
	gf_elem_t [MAX_ECC_LEN-1:0] stage_up;
	gf_elem_t [MAX_ECC_LEN-1:0] stage_nx;
	gf_elem_t [MAX_ECC_LEN-1:0] obuf_q;
	logic [NW-1:0]              rem_q;
	gf_elem_t                   fb;
	logic                       in_acc;
	logic                       out_acc;
	logic                       out_free;

	// Active length, capped at the stage count
	assign len = (int'(ecc_q) > MAX_ECC_LEN) ? NW'(MAX_ECC_LEN) : NW'(ecc_q);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q <= ECC_LEN_RESET;
		end else if (cfg_we) begin
			ecc_q <= cfg_wdata;
		end
	end

	rspe_gen #(
		.MAX_ECC_LEN(MAX_ECC_LEN),
		.NW         (NW)
	) u_gen (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cfg_we),
		.len   (len),
		.busy  (gen_busy),
		.coef  (coef)
	);

	// Handshakes; a last byte needs the output buffer empty by the end of this cycle
	assign out_acc    = parity_valid && parity_ready;
	assign out_free   = (rem_q == '0) || ((rem_q == NW'(1)) && parity_ready);
	assign data_ready = !gen_busy && (!last_byte || out_free);
	assign in_acc     = data_valid && data_ready;

	// LFSR next state; lanes at and above n keep zero coefficients and stay zero
	assign fb = data_byte ^ stage_q[0];
	always_comb begin
		stage_up[MAX_ECC_LEN-1] = '0;
		for (int k = 0; k < MAX_ECC_LEN - 1; k++) begin
			stage_up[k] = stage_q[k+1];
		end
		for (int k = 0; k < MAX_ECC_LEN; k++) begin
			stage_nx[k] = stage_up[k] ^ gf_mul(coef[k], fb);
		end
	end

	// Division register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else if (cfg_we) begin
			stage_q <= '0;
		end else if (in_acc) begin
			stage_q <= last_byte ? '0 : stage_nx;
		end
	end

	// Output shift register: load on last byte, shift one byte per accepted parity
	always_ff @(posedge clk) begin
		if (in_acc && last_byte) begin
			obuf_q <= stage_nx;
		end else if (out_acc) begin
			obuf_q <= {8'h00, obuf_q[MAX_ECC_LEN-1:1]};
		end
	end

	// Remaining parity count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (in_acc && last_byte) begin
			rem_q <= len;
		end else if (out_acc) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	assign parity_valid = (rem_q != '0);
	assign parity_byte  = obuf_q[0];
	assign last_parity  = (rem_q == NW'(1));

endmodule

// File: hw/rtl/rspe_gen.sv
// Generator polynomial builder: product of (x - alpha^i), i = 0..n-1, one root per cycle.
// Depends on rspe_pkg.
module rspe_gen #(
	parameter int unsigned MAX_ECC_LEN = rspe_pkg::MAX_ECC_LEN_DEF,
	parameter int unsigned NW          = $clog2(MAX_ECC_LEN + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [NW-1:0]                        len,
	output logic                                 busy,
	output rspe_pkg::gf_elem_t [MAX_ECC_LEN-1:0] coef
);
	import rspe_pkg::*;

	typedef enum logic [1:0] {
		G_INIT,
		G_RUN,
		G_DONE
	} gen_state_t;

	gen_state_t                 state_q;
	logic [NW-1:0]              cnt_q;
	gf_elem_t                   root_q;
	gf_elem_t [MAX_ECC_LEN-1:0] coef_q;
	gf_elem_t [MAX_ECC_LEN-1:0] coef_up;

	// Next-higher coefficient for each lane, zero above the top
	always_comb begin
		coef_up[MAX_ECC_LEN-1] = '0;
		for (int k = 0; k < MAX_ECC_LEN - 1; k++) begin
			coef_up[k] = coef_q[k+1];
		end
	end

	// Sequencer: init to monic x^0 term at lane n-1, then multiply by (x - root) n times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_INIT;
			cnt_q   <= '0;
			root_q  <= 8'h01;
			coef_q  <= '0;
		end else if (start) begin
			state_q <= G_INIT;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				G_INIT: begin
					for (int k = 0; k < MAX_ECC_LEN; k++) begin
						coef_q[k] <= (k == int'(len) - 1) ? 8'h01 : 8'h00;
					end
					root_q  <= 8'h01;
					cnt_q   <= '0;
					state_q <= (len == '0) ? G_DONE : G_RUN;
				end
				G_RUN: begin
					for (int k = 0; k < MAX_ECC_LEN; k++) begin
						coef_q[k] <= gf_mul(coef_q[k], root_q) ^ coef_up[k];
					end
					root_q <= gf_xtime(root_q);
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == len - 1'b1) begin
						state_q <= G_DONE;
					end
				end
				G_DONE: begin
					state_q <= G_DONE;
				end
				default: begin
					state_q <= G_INIT;
				end
			endcase
		end
	end

	assign busy = (state_q != G_DONE);
	assign coef = coef_q;

endmodule

// File: hw/rtl/rspe_checker.sv
// Port-level checker for reed_solomon_parity_encoder, with its bind statement.
// Depends on the top level's ports.
module rspe_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_we,
	input logic                       data_valid,
	input logic                       data_ready,
	input logic                       last_byte,
	input logic                       parity_valid,
	input logic                       parity_ready,
	input logic [7:0]                 parity_byte,
	input logic                       last_parity
);

	// A register write restarts the generator build, so no data is taken next cycle
	a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !data_ready)
		else $error("data_ready high right after a length register write");

	// The final-byte flag only appears on a valid parity byte
	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_parity |-> parity_valid)
		else $error("last_parity without parity_valid");

	// After the final parity leaves with no new block closing, the output goes empty
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(parity_valid && parity_ready && last_parity && !(data_valid && data_ready && last_byte))
		|=> !parity_valid)
		else $error("parity_valid stayed high after the final parity byte");

	// A stalled parity byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(parity_valid && !parity_ready)
		|=> (parity_valid && $stable(parity_byte) && $stable(last_parity)))
		else $error("parity output changed while stalled");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (.*);
